FILE: design/hsl_pkg.sv
// Package for the linear-probe hash set: slot flag codes, operation codes,
// controller states and sizing constants. Depends on nothing.
`default_nettype none
package hsl_pkg;

  localparam int unsigned CAPACITY_DEF      = 256;
  localparam int unsigned MAX_KEY_BYTES_DEF = 8;
  localparam logic [31:0] HASH_MUL          = 32'd31;

  typedef enum logic [1:0] {
    FLAG_EMPTY  = 2'd0,
    FLAG_FILLED = 2'd1,
    FLAG_TOMB   = 2'd2,
    FLAG_RSVD   = 2'd3
  } flag_t;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_SPARE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_READ,
    ST_PROBE,
    ST_DONE
  } state_t;

  localparam logic [1:0] REG_TABLE_SIZE = 2'd0;

endpackage
`default_nettype wire

FILE: design/hash_set_linear_probe.sv
// Top level of the linear-probe hash set: controller, hash and modulo unit,
// flag and key memories, APB register. Depends on hsl_pkg.
//
// Each command (start while busy is low) first hashes the key at one character
// per cycle. It then reduces the hash with a restoring divide at one quotient
// bit per cycle. Each probed slot then passes through ST_READ and ST_PROBE,
// since it is read from the registered flag and key memories before it is
// examined. The result appears for one cycle on out_valid. busy drops in the
// cycle after the result, so a new command is taken only after the previous
// result. The receiver cannot stall: each result word must be taken in its
// strobe cycle. Flags reset to empty through one valid bit per slot cleared at
// reset.
`default_nettype none
module hash_set_linear_probe
  import hsl_pkg::*;
#(
  parameter int unsigned CAPACITY      = CAPACITY_DEF,
  parameter int unsigned MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_operation,
  input  wire logic [63:0] in_key,
  output logic             out_valid,
  output logic             out_found,
  output logic [7:0]       out_slot,
  output logic [8:0]       out_element_count,
  output logic             out_status,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned NW = $clog2(CAPACITY + 1);
  localparam int unsigned BW = $clog2(MAX_KEY_BYTES + 1);
  localparam logic [NW-1:0] CAP_N = NW'(CAPACITY);

  // memories and valid bits
  logic [1:0]    flag_mem [CAPACITY];
  logic [63:0]   key_mem  [CAPACITY];
  logic [CAPACITY-1:0] vld_r;
  logic [1:0]    flag_rd_r;
  logic [63:0]   key_rd_r;
  logic          vld_rd_r;

  // registers
  state_t        state_r, state_nxt;
  logic [8:0]    tsize_r;
  op_t           op_r;
  logic [63:0]   raw_r;
  logic [63:0]   key_r, key_nxt;
  logic [31:0]   hash_r, hash_nxt;
  logic [BW-1:0] bcnt_r, bcnt_nxt;
  logic          stop_r, stop_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [31:0]   quo_r, quo_nxt;
  logic [5:0]    dcnt_r, dcnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [NW-1:0] pcnt_r, pcnt_nxt;
  logic          tomb_r, tomb_nxt;
  logic [AW-1:0] free_r, free_nxt;
  logic [8:0]    cnt_r, cnt_nxt;
  logic          found_r, found_nxt;
  logic [7:0]    slot_r, slot_nxt;
  logic          stat_r, stat_nxt;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [1:0]    wr_flag;
  logic          wr_key;

  logic [7:0]    ch;
  logic [NW:0]   trial;
  logic [1:0]    cur_flag;
  logic [NW-1:0] sz_use;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {23'd0, tsize_r} : 32'd0;
  assign busy   = (state_r != ST_IDLE);

  // clamp table size
  always_comb begin
    if (tsize_r == 9'd0) begin
      sz_use = NW'(1);
    end else if (32'(tsize_r) > 32'(CAPACITY)) begin
      sz_use = CAP_N;
    end else begin
      sz_use = NW'(tsize_r);
    end
  end

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsize_r <= 9'd256;
    end else if (psel && penable && pwrite && paddr[2] == REG_TABLE_SIZE[0]) begin
      tsize_r <= pwdata[8:0];
    end
  end

  assign ch       = raw_r[{3'(bcnt_r), 3'b000} +: 8];
  assign trial    = {rem_r, quo_r[31]};
  assign cur_flag = vld_rd_r ? flag_rd_r : FLAG_EMPTY;

  // next state and datapath
  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    hash_nxt  = hash_r;
    bcnt_nxt  = bcnt_r;
    stop_nxt  = stop_r;
    n_nxt     = n_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dcnt_nxt  = dcnt_r;
    idx_nxt   = idx_r;
    pcnt_nxt  = pcnt_r;
    tomb_nxt  = tomb_r;
    free_nxt  = free_r;
    cnt_nxt   = cnt_r;
    found_nxt = found_r;
    slot_nxt  = slot_r;
    stat_nxt  = stat_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_flag   = FLAG_FILLED;
    wr_key    = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_HASH;
          key_nxt   = 64'd0;
          hash_nxt  = 32'd0;
          bcnt_nxt  = '0;
          stop_nxt  = 1'b0;
          n_nxt     = sz_use;
        end
      end
      // fold one character per cycle
      ST_HASH: begin
        if (bcnt_r == BW'(MAX_KEY_BYTES) || stop_r || ch == 8'd0) begin
          state_nxt = ST_MOD;
          rem_nxt   = '0;
          quo_nxt   = hash_r;
          dcnt_nxt  = 6'd0;
        end else begin
          hash_nxt = hash_r * HASH_MUL + {24'd0, ch};
          key_nxt  = key_r | ({56'd0, ch} << (8 * bcnt_r));
          bcnt_nxt = bcnt_r + BW'(1);
        end
      end
      // restoring divide, one bit a cycle
      ST_MOD: begin
        quo_nxt  = {quo_r[30:0], 1'b0};
        dcnt_nxt = dcnt_r + 6'd1;
        if (trial >= {1'b0, n_r}) begin
          rem_nxt = NW'(trial - {1'b0, n_r});
        end else begin
          rem_nxt = NW'(trial);
        end
        if (dcnt_r == 6'd31) begin
          state_nxt = ST_READ;
          pcnt_nxt  = '0;
          tomb_nxt  = 1'b0;
          free_nxt  = '0;
        end
      end
      ST_READ: begin
        if (pcnt_r == '0) begin
          idx_nxt = AW'(rem_r);
        end
        state_nxt = ST_PROBE;
      end
      // examine one slot
      ST_PROBE: begin
        priority if (cur_flag == FLAG_EMPTY) begin
          found_nxt = 1'b0;
          stat_nxt  = 1'b0;
          slot_nxt  = 8'd0;
          if (op_r == OP_ADD) begin
            wr_en    = 1'b1;
            wr_key   = 1'b1;
            wr_addr  = tomb_r ? free_r : idx_r;
            slot_nxt = 8'(wr_addr);
            cnt_nxt  = cnt_r + 9'd1;
          end
          state_nxt = ST_DONE;
        end else if (cur_flag == FLAG_FILLED && key_rd_r == key_r) begin
          found_nxt = 1'b1;
          stat_nxt  = 1'b0;
          slot_nxt  = 8'(idx_r);
          if (op_r == OP_REMOVE) begin
            wr_en   = 1'b1;
            wr_flag = FLAG_TOMB;
            if (cnt_r != 9'd0) cnt_nxt = cnt_r - 9'd1;
          end
          state_nxt = ST_DONE;
        end else begin
          if (cur_flag == FLAG_TOMB && !tomb_r) begin
            tomb_nxt = 1'b1;
            free_nxt = idx_r;
          end
          if (pcnt_r + NW'(1) == n_r) begin
            found_nxt = 1'b0;
            stat_nxt  = 1'b0;
            slot_nxt  = 8'd0;
            if (op_r == OP_ADD) begin
              if (tomb_r || cur_flag == FLAG_TOMB) begin
                wr_en    = 1'b1;
                wr_key   = 1'b1;
                wr_addr  = tomb_r ? free_r : idx_r;
                slot_nxt = 8'(wr_addr);
                cnt_nxt  = cnt_r + 9'd1;
              end else begin
                stat_nxt = 1'b1;
              end
            end
            state_nxt = ST_DONE;
          end else begin
            pcnt_nxt  = pcnt_r + NW'(1);
            idx_nxt   = (NW'(idx_r) + NW'(1) >= n_r) ? '0 : idx_r + AW'(1);
            state_nxt = ST_READ;
          end
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_found         = found_r;
  assign out_slot          = slot_r;
  assign out_element_count = cnt_r;
  assign out_status        = stat_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 9'd0;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (wr_en) vld_r[wr_addr] <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      op_r  <= op_t'(in_operation);
      raw_r <= in_key;
    end
    key_r   <= key_nxt;
    hash_r  <= hash_nxt;
    bcnt_r  <= bcnt_nxt;
    stop_r  <= stop_nxt;
    n_r     <= n_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    dcnt_r  <= dcnt_nxt;
    idx_r   <= idx_nxt;
    pcnt_r  <= pcnt_nxt;
    tomb_r  <= tomb_nxt;
    free_r  <= free_nxt;
    found_r <= found_nxt;
    slot_r  <= slot_nxt;
    stat_r  <= stat_nxt;
  end

  // memories: read at the probe index, write back on remove hit or add fill
  always_ff @(posedge clk) begin
    if (wr_en) begin
      flag_mem[wr_addr] <= wr_flag;
      if (wr_key) key_mem[wr_addr] <= key_r;
    end
    flag_rd_r <= flag_mem[idx_nxt];
    key_rd_r  <= key_mem[idx_nxt];
    vld_rd_r  <= vld_r[idx_nxt];
  end

  // checks
  a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  a_busy_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command not taken");
  a_full_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_slot == 8'd0 && !out_found))
    else $error("rejected add reports a slot");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_element_count <= 9'(CAPACITY)))
    else $error("count above capacity");

endmodule
`default_nettype wire

FILE: sim/hash_set_linear_probe_tb.sv
// Self-checking bench for the linear-probe hash set: drives add/remove/find/spare
// words, predicts each result from its own table model. Depends on hsl_pkg.
`default_nettype none
module hash_set_linear_probe_tb;
  import hsl_pkg::*;

  localparam int unsigned SLOTS = 256;
  localparam int unsigned RANDOM_WORDS = 1900;
  localparam longint unsigned CYCLE_LIMIT = 6_000_000;

  typedef struct packed {
    logic       found;
    logic [7:0] slot;
    logic [8:0] count;
    logic       status;
  } result_t;

  typedef struct {
    op_t          op;
    logic [63:0]  key;
    bit           typed;
    result_t      res;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_operation = '0;
  logic [63:0] in_key = '0;
  logic        out_valid, out_found, out_status;
  logic [7:0]  out_slot;
  logic [8:0]  out_element_count;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Model state of the set
  flag_t       set_flags [SLOTS];
  logic [63:0] set_keys [SLOTS];
  int unsigned set_count;
  int unsigned set_size;

  result_t     pending_results[$];
  int          error_count = 0;
  longint unsigned cycle_count = 0;
  stim_t       directed[$];

  hash_set_linear_probe i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_key(in_key),
    .out_valid(out_valid), .out_found(out_found), .out_slot(out_slot),
    .out_element_count(out_element_count), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Predict one result and update the model table
  function automatic result_t apply_word(op_t op, logic [63:0] raw);
    logic [63:0] k;
    logic [31:0] h;
    int unsigned idx, free_idx, n;
    bit stop, hit, have_tomb, have_empty;
    result_t r;
    k = '0; h = '0; stop = 0; hit = 0; have_tomb = 0; have_empty = 0;
    free_idx = 0;
    r = '0;
    for (int b = 0; b < 8; b++) begin
      if (raw[8*b +: 8] == 8'd0) stop = 1;
      if (!stop) begin
        h = h * 32'd31 + {24'd0, raw[8*b +: 8]};
        k[8*b +: 8] = raw[8*b +: 8];
      end
    end
    n = (set_size == 0) ? 1 : (set_size > SLOTS ? SLOTS : set_size);
    idx = h % n;
    stop = 0;
    for (int i = 0; i < n && !stop; i++) begin
      if (set_flags[idx] == FLAG_EMPTY) begin
        have_empty = 1;
        if (!have_tomb) free_idx = idx;
        stop = 1;
      end else if (set_flags[idx] == FLAG_FILLED && set_keys[idx] == k) begin
        hit = 1;
        r.slot = idx[7:0];
        stop = 1;
      end else begin
        if (set_flags[idx] == FLAG_TOMB && !have_tomb) begin
          have_tomb = 1;
          free_idx = idx;
        end
        idx = (idx + 1 >= n) ? 0 : idx + 1;
      end
    end
    if (hit) begin
      r.found = 1'b1;
      if (op == OP_REMOVE) begin
        set_flags[r.slot] = FLAG_TOMB;
        if (set_count > 0) set_count--;
      end
    end else if (op == OP_ADD) begin
      if (have_empty || have_tomb) begin
        set_flags[free_idx] = FLAG_FILLED;
        set_keys[free_idx] = k;
        set_count++;
        r.slot = free_idx[7:0];
      end else begin
        r.status = 1'b1;
      end
    end
    r.count = set_count[8:0];
    return r;
  endfunction

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result word with no prediction waiting");
        error_count++;
      end else begin
        result_t e;
        e = pending_results.pop_front();
        if (out_found !== e.found) begin
          $error("found exp %0d got %0d", e.found, out_found); error_count++;
        end
        if (out_slot !== e.slot) begin
          $error("slot exp %0d got %0d", e.slot, out_slot); error_count++;
        end
        if (out_element_count !== e.count) begin
          $error("element_count exp %0d got %0d", e.count, out_element_count);
          error_count++;
        end
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status); error_count++;
        end
      end
    end
  end

  // Issue one command word and queue its prediction
  task automatic send_word(op_t op, logic [63:0] key, bit idle_ok);
    result_t r;
    if (idle_ok && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 14)) @(posedge clk);
    start <= 1'b1;
    in_operation <= op;
    in_key <= key;
    r = apply_word(op, key);
    pending_results.push_back(r);
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    in_operation <= 2'($urandom);
    in_key <= {$urandom, $urandom};
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write table_size over the APB port; block must be idle
  task automatic write_size(logic [31:0] value);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {REG_TABLE_SIZE[0], 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    set_size = value[8:0];
    @(posedge clk);
  endtask

  // Keys from a small pool so adds, finds and removes collide often
  function automatic logic [63:0] pool_key(int unsigned pool);
    logic [63:0] k;
    int unsigned len;
    len = $urandom_range(0, 8);
    k = '0;
    for (int b = 0; b < 8; b++)
      if (b < len) k[8*b +: 8] = 8'($urandom_range(1, pool));
    return k;
  endfunction

  function automatic stim_t row(op_t op, logic [63:0] key, bit typed,
                                logic f, logic [7:0] s, logic [8:0] c, logic st);
    stim_t t;
    t.op = op; t.key = key; t.typed = typed;
    t.res = '{found: f, slot: s, count: c, status: st};
    return t;
  endfunction

  initial begin
    stim_t t;
    result_t r;
    int unsigned pool;
    for (int i = 0; i < SLOTS; i++) begin
      set_flags[i] = FLAG_EMPTY;
      set_keys[i] = '0;
    end
    set_count = 0;
    set_size = 256;

    // Directed table: empty key, extremes, every operation
    directed.push_back(row(OP_FIND,   64'h0, 1, 0, 0, 0, 0));
    directed.push_back(row(OP_ADD,    64'h0, 1, 0, 0, 1, 0));
    directed.push_back(row(OP_ADD,    64'h0, 1, 1, 0, 1, 0));
    directed.push_back(row(OP_REMOVE, 64'hFFFF_0000_0000_0000, 1, 1, 0, 0, 0));
    directed.push_back(row(OP_ADD,    64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0));
    directed.push_back(row(OP_FIND,   64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0));
    directed.push_back(row(OP_SPARE,  64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0));
    directed.push_back(row(OP_ADD,    64'h41, 0, 0, 0, 0, 0));
    directed.push_back(row(OP_ADD,    64'h4100_0000_0000_0041, 0, 0, 0, 0, 0));
    directed.push_back(row(OP_REMOVE, 64'h41, 0, 0, 0, 0, 0));
    directed.push_back(row(OP_REMOVE, 64'h41, 0, 0, 0, 0, 0));
    directed.push_back(row(OP_ADD,    64'h8081_8283_8485_8687, 0, 0, 0, 0, 0));
    directed.push_back(row(OP_FIND,   64'h0081_8283_8485_8687, 0, 0, 0, 0, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      t = directed[i];
      r = apply_word(t.op, t.key);
      if (t.typed && r != t.res) begin
        $error("directed row %0d prediction differs from table", i);
        error_count++;
      end
      // Queue the prediction and issue the word
      pending_results.push_back(r);
      start <= 1'b1; in_operation <= t.op; in_key <= t.key;
      @(posedge clk);
      while (busy) @(posedge clk);
      start <= 1'b0;
      @(posedge clk);
    end

    // Size one: fill the single slot, then a rejected add
    write_size(32'd1);
    send_word(OP_ADD, 64'h5A5A, 0);
    send_word(OP_ADD, 64'h1234, 0);
    // Size zero is used as one
    write_size(32'd0);
    send_word(OP_FIND, 64'h1234, 0);
    send_word(OP_ADD, 64'h77, 0);

    // Random phases over several sizes, sender pauses till idle between them
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_size(32'd4);
        1: write_size(32'd256);
        2: write_size(32'd17);
        3: write_size(32'h1FF);
        4: write_size(32'd2);
        5: write_size(32'd64);
        6: write_size(32'hFFFF_FE08);
        default: write_size(32'd256);
      endcase
      pool = (ph == 1 || ph == 3) ? 127 : 3;
      for (int n = 0; n < RANDOM_WORDS / 8; n++) begin
        int unsigned pick;
        op_t op;
        pick = $urandom_range(0, 9);
        op = pick < 5 ? OP_ADD : (pick < 8 ? OP_REMOVE : (pick < 9 ? OP_FIND : OP_SPARE));
        if ($urandom_range(0, 19) == 0)
          send_word(op, {$urandom, $urandom}, ph != 7);
        else
          send_word(op, pool_key(pool), ph != 7);
      end
    end

    drain();
    repeat (600) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
